// File: rtl/cmed_pkg.sv
`default_nettype none

package cmed_pkg;

	localparam int CHAR_W = 8;
	localparam int DIST_W = 6;
	localparam int IDX_W  = 8;
	localparam int S_TDATA_W = 8;
	localparam int TDATA_W = 32;
	localparam int S_TUSER_W = 3;
	localparam int M_TUSER_W = 2;

	localparam logic FUNC_QUERY = 1'b0;
	localparam logic FUNC_CAND  = 1'b1;

	localparam logic [DIST_W-1:0] MAX_DIST_RESET = 6'd2;

	typedef struct packed {
		logic [IDX_W-1:0]  cand_index;
		logic [DIST_W-1:0] distance;
		logic              is_final;
		logic              found;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] min_dist;
		logic              overflow;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/cmed_ram.sv
`default_nettype none

module cmed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/cmed_cell.sv
`default_nettype none

module cmed_cell import cmed_pkg::*; #(
	parameter int DW = 6
) (
	input  wire logic [DW-1:0]     up,
	input  wire logic [DW-1:0]     left,
	input  wire logic [DW-1:0]     diag,
	input  wire logic [CHAR_W-1:0] q_char,
	input  wire logic [CHAR_W-1:0] c_char,
	output logic      [DW-1:0]     cost
);

	logic [DW-1:0] del_c;
	logic [DW-1:0] ins_c;
	logic [DW-1:0] sub_c;
	logic [DW-1:0] m1;

	always_comb begin
		del_c = up + DW'(1);
		ins_c = left + DW'(1);
		sub_c = diag + DW'(q_char != c_char);
		m1 = (ins_c < del_c) ? ins_c : del_c;
		cost = (sub_c < m1) ? sub_c : m1;
	end

endmodule

`default_nettype wire

// File: rtl/closest_match_edit_distance_core.sv
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata: char_code; s_tlast: last_char;
//                                  s_tuser: func, has_char, last_candidate
// m        out  m_tvalid/m_tready  m_tdata: candidate_index, distance, best_index,
//                                  min_dist; m_tlast: is_final; m_tuser: found, overflow
// cfg      in   cfg_wen            cfg_wdata: match limit
//
// A candidate character is processed by the single cell unit, which walks the column
// memory one query character per cycle. Closing a candidate waits in ST_FIN while the
// previous result is not taken.
// Reset clears the state machine and counters; the column uses per-entry valid bits.
// The input is not ready while a column update or a result hand-off is in progress.
`default_nettype none

module closest_match_edit_distance_core import cmed_pkg::*; #(
	parameter int MAX_LEN = 32,
	parameter int MAX_CANDIDATES = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // char_code
	input  wire logic                 s_tlast,
	input  wire logic [S_TUSER_W-1:0] s_tuser,   // func, has_char, last_candidate
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [TDATA_W-1:0]        m_tdata,   // candidate_index, distance, best_index,
	                                             // min_dist, zero fill
	output logic                      m_tlast,
	output logic [M_TUSER_W-1:0]      m_tuser,   // found, overflow
	input  wire logic                 cfg_wen,
	input  wire logic [DIST_W-1:0]    cfg_wdata
);

	localparam int CELL_W = $clog2(MAX_LEN + 1);
	localparam int DW = $clog2(MAX_LEN + 2);
	localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CMP_W = (DW > DIST_W) ? DW : DIST_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [DIST_W-1:0] max_dist_q;
	logic [CELL_W-1:0] qlen_q;
	logic              query_done_q;
	logic              ovf_q;
	logic [CELL_W-1:0] cand_len_q;
	logic [CNT_W-1:0]  count_q;
	logic [DW-1:0]     best_q;
	logic [CNT_W-1:0]  best_pos_q;
	logic              best_valid_q;
	logic [MAX_LEN-1:0] dpv_q;
	logic [CELL_W-1:0] cell_q;
	logic [DW-1:0]     diag_q;
	logic [DW-1:0]     left_q;
	logic [DW-1:0]     last_v_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              final_q;
	logic              m_tvalid_q;
	result_t           res_q;

	logic              acc;
	logic              in_func;
	logic              in_has;
	logic              in_last_cand;
	logic [CHAR_W-1:0] in_char;
	logic [CELL_W-1:0] q_eff;
	logic              q_we;
	logic [QAW-1:0]    rd_addr;
	logic [CELL_W-1:0] cell_m1;
	logic [QAW-1:0]    dp_waddr;
	logic [DW-1:0]     dp_rdata;
	logic [CHAR_W-1:0] q_rdata;
	logic [DW-1:0]     up;
	logic [DW-1:0]     cost;
	logic              run_we;
	logic              out_free;
	logic [DW-1:0]     cand_dist;
	logic              new_best;
	logic [DW-1:0]     best_next;
	logic [CNT_W-1:0]  pos_next;

	always_comb begin
		acc = s_tvalid && s_tready;
		in_func = s_tuser[0];
		in_has = s_tuser[1];
		in_last_cand = s_tuser[2];
		in_char = s_tdata[CHAR_W-1:0];
		q_eff = query_done_q ? '0 : qlen_q;
		q_we = acc && (in_func == FUNC_QUERY) && in_has && (q_eff < CELL_W'(MAX_LEN));
		rd_addr = (state_q == ST_RUN) ? cell_q[QAW-1:0] : '0;
		cell_m1 = cell_q - CELL_W'(1);
		dp_waddr = cell_m1[QAW-1:0];
		up = dpv_q[dp_waddr] ? dp_rdata : DW'(cell_q);
		run_we = (state_q == ST_RUN);
		out_free = !m_tvalid_q || m_tready;
		if (qlen_q == '0) begin
			cand_dist = DW'(cand_len_q);
		end else if (cand_len_q == '0) begin
			cand_dist = DW'(qlen_q);
		end else begin
			cand_dist = last_v_q;
		end
		new_best = !best_valid_q || (cand_dist < best_q);
		best_next = new_best ? cand_dist : best_q;
		pos_next = new_best ? count_q : best_pos_q;
	end

	cmed_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_LEN),
		.AW(QAW)
	) u_query_ram (
		.clk(clk),
		.we(q_we),
		.waddr(q_eff[QAW-1:0]),
		.wdata(in_char),
		.raddr(rd_addr),
		.rdata(q_rdata)
	);

	cmed_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_LEN),
		.AW(QAW)
	) u_col_ram (
		.clk(clk),
		.we(run_we),
		.waddr(dp_waddr),
		.wdata(cost),
		.raddr(rd_addr),
		.rdata(dp_rdata)
	);

	cmed_cell #(
		.DW(DW)
	) u_cell (
		.up(up),
		.left(left_q),
		.diag(diag_q),
		.q_char(q_rdata),
		.c_char(char_q),
		.cost(cost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_dist_q <= MAX_DIST_RESET;
			qlen_q <= '0;
			query_done_q <= 1'b0;
			ovf_q <= 1'b0;
			cand_len_q <= '0;
			count_q <= '0;
			best_q <= '1;
			best_pos_q <= '0;
			best_valid_q <= 1'b0;
			dpv_q <= '0;
			cell_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_dist_q <= cfg_wdata;
			end
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						last_q <= s_tlast;
						final_q <= in_last_cand;
						if (in_func == FUNC_QUERY) begin
							if (query_done_q) begin
								cand_len_q <= '0;
								count_q <= '0;
								best_q <= '1;
								best_pos_q <= '0;
								best_valid_q <= 1'b0;
								dpv_q <= '0;
							end
							query_done_q <= s_tlast;
							if (in_has && (q_eff < CELL_W'(MAX_LEN))) begin
								qlen_q <= q_eff + CELL_W'(1);
							end else begin
								qlen_q <= q_eff;
							end
							ovf_q <= (ovf_q && !query_done_q) ||
								(in_has && (q_eff >= CELL_W'(MAX_LEN)));
						end else begin
							query_done_q <= 1'b1;
							if (in_has && (cand_len_q < CELL_W'(MAX_LEN))) begin
								cand_len_q <= cand_len_q + CELL_W'(1);
								char_q <= in_char;
								diag_q <= DW'(cand_len_q);
								left_q <= DW'(cand_len_q) + DW'(1);
								cell_q <= CELL_W'(1);
								if (qlen_q != '0) begin
									state_q <= ST_RUN;
								end else if (s_tlast) begin
									state_q <= ST_FIN;
								end
							end else begin
								if (in_has) begin
									ovf_q <= 1'b1;
								end
								if (s_tlast) begin
									state_q <= ST_FIN;
								end
							end
						end
					end
				end
				ST_RUN: begin
					dpv_q[dp_waddr] <= 1'b1;
					diag_q <= up;
					left_q <= cost;
					last_v_q <= cost;
					cell_q <= cell_q + CELL_W'(1);
					if (cell_q == qlen_q) begin
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_q.cand_index <= IDX_W'(count_q);
						res_q.distance <= DIST_W'(cand_dist);
						res_q.is_final <= final_q;
						res_q.found <= final_q && (CMP_W'(best_next) <= CMP_W'(max_dist_q));
						res_q.best_index <= IDX_W'(pos_next);
						res_q.min_dist <= DIST_W'(best_next);
						res_q.overflow <= ovf_q;
						cand_len_q <= '0;
						dpv_q <= '0;
						if (final_q) begin
							count_q <= '0;
							best_q <= '1;
							best_pos_q <= '0;
							best_valid_q <= 1'b0;
						end else begin
							best_q <= best_next;
							best_pos_q <= pos_next;
							best_valid_q <= 1'b1;
							if (count_q < CNT_W'(MAX_CANDIDATES - 1)) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = m_tvalid_q;
		m_tdata = {
			{(TDATA_W - 2 * IDX_W - 2 * DIST_W){1'b0}},
			res_q.min_dist,
			res_q.best_index,
			res_q.distance,
			res_q.cand_index
		};
		m_tlast = res_q.is_final;
		m_tuser = {res_q.overflow, res_q.found};
	end

	a_run_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((cell_q != '0) && (cell_q <= qlen_q)))
		else $error("column walk outside the query");

	a_cand_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cand_len_q <= CELL_W'(MAX_LEN))
		else $error("candidate length beyond limit");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && m_tvalid_q && !m_tready) |=> (state_q == ST_FIN))
		else $error("result dropped while output busy");

	a_found_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tuser[0])
		else $error("found set on a result that is not final");

endmodule

`default_nettype wire
